// ===== rtl/core/sdfd_pkg.sv =====
// Shared constants, types and helpers for the SPI slave dual-FIFO deframer.
package sdfd_pkg;

    localparam int FIFO_DEPTH  = 32;
    localparam int PACKET_LEN  = 11;
    localparam int PAYLOAD_LEN = PACKET_LEN - 1;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int PAY_W = $clog2(PAYLOAD_LEN);

    typedef logic [7:0]       byte_t;
    typedef logic [1:0]       opcode_t;
    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [PAY_W-1:0] pay_cnt_t;

    // Operation codes carried on the input channel.
    localparam opcode_t OP_XFER   = 2'd0;
    localparam opcode_t OP_POP    = 2'd1;
    localparam opcode_t OP_PUSH   = 2'd2;
    localparam opcode_t OP_PACKET = 2'd3;

    // Special byte values.
    localparam byte_t FILLER     = 8'hFD;
    localparam byte_t EMPTY_CODE = 8'hFE;
    localparam byte_t HEADER     = 8'hFF;

    localparam ptr_t     PTR_LAST   = PTR_W'(FIFO_DEPTH - 1);
    localparam cnt_t     DEPTH_CNT  = CNT_W'(FIFO_DEPTH);
    localparam cnt_t     PACKET_CNT = CNT_W'(PACKET_LEN);
    localparam pay_cnt_t PAY_LAST   = PAY_W'(PAYLOAD_LEN - 1);

    // Ring pointer advance with wrap at the FIFO depth.
    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (p == PTR_LAST)
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/sdfd_in_if.sv =====
// Input channel of the deframer: operation code and data byte with valid/ready.
interface sdfd_in_if;
    logic               valid;
    logic               ready;
    sdfd_pkg::opcode_t  opcode;
    sdfd_pkg::byte_t    data_in;

    modport source (output valid, output opcode, output data_in, input ready);
    modport sink   (input valid, input opcode, input data_in, output ready);
endinterface

// ===== rtl/core/sdfd_out_if.sv =====
// Result channel of the deframer: data byte plus status flags with valid/ready.
interface sdfd_out_if;
    logic            valid;
    logic            ready;
    sdfd_pkg::byte_t data_out;
    logic            data_valid;
    logic            last_of_run;
    sdfd_pkg::byte_t shift_out_byte;
    logic            handshake_level;
    logic            rx_not_empty;
    logic            package_ready;
    logic            rx_overflow;
    logic            tx_dropped;

    modport source (
        output valid, output data_out, output data_valid, output last_of_run,
        output shift_out_byte, output handshake_level, output rx_not_empty,
        output package_ready, output rx_overflow, output tx_dropped,
        input ready
    );
    modport sink (
        input valid, input data_out, input data_valid, input last_of_run,
        input shift_out_byte, input handshake_level, input rx_not_empty,
        input package_ready, input rx_overflow, input tx_dropped,
        output ready
    );
endinterface

// ===== rtl/core/spi_slave_dual_fifo_deframer.sv =====
// Byte-level SPI slave with receive and transmit ring FIFOs and a packet reader.
//
// The block takes one beat at a time on in_ch and returns its results on out_ch.
// A transfer-done beat queues the master's byte in the receive FIFO (the 0xFD
// filler is ignored, and a byte that finds the FIFO full is dropped with
// rx_overflow set), then loads the next transmit byte, or filler, into the out
// register and drives the request line. Host beats pop a receive byte (0xFE
// with data_valid low when empty), push a transmit byte (dropped with
// tx_dropped set when full), or read a packet: bytes ahead of the 0xFF header
// are discarded, then the header and ten payload bytes are taken and the ten
// payload bytes come out as ten result beats, the last one marked by
// last_of_run. A packet read that runs short of a whole packet gives one 0xFE
// result. Each FIFO is a memory with registered read data, walked by a small
// sequencer, and that read port sets the timing. A push, or a transfer with
// nothing to transmit, goes from acceptance straight to the result load; a
// pop first reads the receive memory, and a transfer with a transmit byte
// pending first reads the transmit memory and loads that byte into the out
// register. A packet read checks the fill level and tests one byte at a time
// until it meets the header, then reads and emits the payload bytes in turn;
// a read that runs short stops at the fill-level check. A result load waits
// while the previous result is still held. in_ch is ready again once the
// last result is loaded, while that result still waits to be taken. Status
// fields in every result show the state after the whole beat has been
// processed.
module spi_slave_dual_fifo_deframer (
    input  logic       clk,
    input  logic       rst_n,
    sdfd_in_if.sink    in_ch,
    sdfd_out_if.source out_ch
);
    import sdfd_pkg::*;

    // Sequencer state codes.
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_XFER_LOAD = 3'd1;
    localparam logic [2:0] ST_POP_DATA  = 3'd2;
    localparam logic [2:0] ST_PK_CHECK  = 3'd3;
    localparam logic [2:0] ST_PK_TEST   = 3'd4;
    localparam logic [2:0] ST_PK_READ   = 3'd5;
    localparam logic [2:0] ST_PK_EMIT   = 3'd6;
    localparam logic [2:0] ST_EMIT      = 3'd7;

    // Control state.
    logic [2:0] state_reg, state_next;
    ptr_t       rx_head_reg, rx_head_next;
    ptr_t       rx_tail_reg, rx_tail_next;
    cnt_t       rx_count_reg, rx_count_next;
    ptr_t       tx_head_reg, tx_head_next;
    ptr_t       tx_tail_reg, tx_tail_next;
    cnt_t       tx_count_reg, tx_count_next;
    byte_t      out_register_reg, out_register_next;
    logic       chain_busy_reg, chain_busy_next;
    logic       request_line_reg, request_line_next;
    logic       ovf_reg, ovf_next;
    logic       drop_reg, drop_next;
    pay_cnt_t   pay_cnt_reg, pay_cnt_next;

    // Output register.
    logic       out_valid_reg;
    byte_t      out_data_reg;
    logic       out_dvalid_reg;
    logic       out_last_reg;
    byte_t      out_shift_reg;
    logic       out_hs_reg;
    logic       out_rxne_reg;
    logic       out_pkrdy_reg;
    logic       out_ovf_reg;
    logic       out_drop_reg;

    // FIFO storage and its registered read data.
    byte_t      rx_mem [FIFO_DEPTH];
    byte_t      tx_mem [FIFO_DEPTH];
    byte_t      rx_rd_data_reg;
    byte_t      tx_rd_data_reg;

    logic       rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en;
    logic       slot_free;
    logic       load_out;
    byte_t      load_data;
    logic       load_valid;
    logic       load_last;

    // The output slot can take a new result when empty or being drained now.
    assign slot_free   = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next        = state_reg;
        rx_head_next      = rx_head_reg;
        rx_tail_next      = rx_tail_reg;
        rx_count_next     = rx_count_reg;
        tx_head_next      = tx_head_reg;
        tx_tail_next      = tx_tail_reg;
        tx_count_next     = tx_count_reg;
        out_register_next = out_register_reg;
        chain_busy_next   = chain_busy_reg;
        request_line_next = request_line_reg;
        ovf_next          = ovf_reg;
        drop_next         = drop_reg;
        pay_cnt_next      = pay_cnt_reg;
        rx_wr_en          = 1'b0;
        rx_rd_en          = 1'b0;
        tx_wr_en          = 1'b0;
        tx_rd_en          = 1'b0;
        load_out          = 1'b0;
        load_data         = EMPTY_CODE;
        load_valid        = 1'b0;
        load_last         = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    ovf_next  = 1'b0;
                    drop_next = 1'b0;
                    case (in_ch.opcode)
                        OP_XFER:
                        begin
                            request_line_next = 1'b0;
                            if (in_ch.data_in != FILLER)
                            begin
                                if (rx_count_reg < DEPTH_CNT)
                                begin
                                    rx_wr_en      = 1'b1;
                                    rx_tail_next  = ptr_inc(rx_tail_reg);
                                    rx_count_next = rx_count_reg + 1'b1;
                                end
                                else
                                begin
                                    ovf_next = 1'b1;
                                end
                            end
                            if (tx_count_reg != '0)
                            begin
                                // The byte itself arrives from memory next cycle.
                                tx_rd_en          = 1'b1;
                                tx_head_next      = ptr_inc(tx_head_reg);
                                tx_count_next     = tx_count_reg - 1'b1;
                                request_line_next = 1'b1;
                                state_next        = ST_XFER_LOAD;
                            end
                            else
                            begin
                                out_register_next = FILLER;
                                chain_busy_next   = 1'b0;
                                state_next        = ST_EMIT;
                            end
                        end
                        OP_POP:
                        begin
                            if (rx_count_reg != '0)
                            begin
                                rx_rd_en      = 1'b1;
                                rx_head_next  = ptr_inc(rx_head_reg);
                                rx_count_next = rx_count_reg - 1'b1;
                                state_next    = ST_POP_DATA;
                            end
                            else
                            begin
                                state_next = ST_EMIT;
                            end
                        end
                        OP_PUSH:
                        begin
                            if (tx_count_reg == '0 && !chain_busy_reg)
                            begin
                                // Idle chain: the pushed byte goes straight out.
                                out_register_next = in_ch.data_in;
                                request_line_next = 1'b1;
                                chain_busy_next   = 1'b1;
                            end
                            else if (tx_count_reg < DEPTH_CNT)
                            begin
                                tx_wr_en      = 1'b1;
                                tx_tail_next  = ptr_inc(tx_tail_reg);
                                tx_count_next = tx_count_reg + 1'b1;
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                            state_next = ST_EMIT;
                        end
                        OP_PACKET:
                        begin
                            state_next = ST_PK_CHECK;
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_XFER_LOAD:
            begin
                out_register_next = tx_rd_data_reg;
                state_next        = ST_EMIT;
            end
            ST_POP_DATA:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    load_data  = rx_rd_data_reg;
                    load_valid = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_PK_CHECK:
            begin
                if (rx_count_reg >= PACKET_CNT)
                begin
                    rx_rd_en   = 1'b1;
                    state_next = ST_PK_TEST;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_PK_TEST:
            begin
                rx_head_next = ptr_inc(rx_head_reg);
                if (rx_rd_data_reg == HEADER)
                begin
                    // Take the whole packet off the count now so that every
                    // payload result already reports the final fill level.
                    rx_count_next = rx_count_reg - PACKET_CNT;
                    pay_cnt_next  = '0;
                    state_next    = ST_PK_READ;
                end
                else
                begin
                    rx_count_next = rx_count_reg - 1'b1;
                    state_next    = ST_PK_CHECK;
                end
            end
            ST_PK_READ:
            begin
                rx_rd_en     = 1'b1;
                rx_head_next = ptr_inc(rx_head_reg);
                state_next   = ST_PK_EMIT;
            end
            ST_PK_EMIT:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    load_data  = rx_rd_data_reg;
                    load_valid = 1'b1;
                    load_last  = (pay_cnt_reg == PAY_LAST);
                    if (pay_cnt_reg == PAY_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pay_cnt_next = pay_cnt_reg + 1'b1;
                        state_next   = ST_PK_READ;
                    end
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            rx_head_reg      <= '0;
            rx_tail_reg      <= '0;
            rx_count_reg     <= '0;
            tx_head_reg      <= '0;
            tx_tail_reg      <= '0;
            tx_count_reg     <= '0;
            out_register_reg <= FILLER;
            chain_busy_reg   <= 1'b0;
            request_line_reg <= 1'b0;
            ovf_reg          <= 1'b0;
            drop_reg         <= 1'b0;
            pay_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rx_head_reg      <= rx_head_next;
            rx_tail_reg      <= rx_tail_next;
            rx_count_reg     <= rx_count_next;
            tx_head_reg      <= tx_head_next;
            tx_tail_reg      <= tx_tail_next;
            tx_count_reg     <= tx_count_next;
            out_register_reg <= out_register_next;
            chain_busy_reg   <= chain_busy_next;
            request_line_reg <= request_line_next;
            ovf_reg          <= ovf_next;
            drop_reg         <= drop_next;
            pay_cnt_reg      <= pay_cnt_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; status is sampled once the beat's state updates are done.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg   <= load_data;
            out_dvalid_reg <= load_valid;
            out_last_reg   <= load_last;
            out_shift_reg  <= out_register_reg;
            out_hs_reg     <= request_line_reg;
            out_rxne_reg   <= (rx_count_reg != '0);
            out_pkrdy_reg  <= (rx_count_reg >= PACKET_CNT);
            out_ovf_reg    <= ovf_reg;
            out_drop_reg   <= drop_reg;
        end
    end

    // Receive FIFO memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (rx_wr_en)
        begin
            rx_mem[rx_tail_reg] <= in_ch.data_in;
        end
        if (rx_rd_en)
        begin
            rx_rd_data_reg <= rx_mem[rx_head_reg];
        end
    end

    // Transmit FIFO memory.
    always_ff @(posedge clk)
    begin
        if (tx_wr_en)
        begin
            tx_mem[tx_tail_reg] <= in_ch.data_in;
        end
        if (tx_rd_en)
        begin
            tx_rd_data_reg <= tx_mem[tx_head_reg];
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.data_out        = out_data_reg;
    assign out_ch.data_valid      = out_dvalid_reg;
    assign out_ch.last_of_run     = out_last_reg;
    assign out_ch.shift_out_byte  = out_shift_reg;
    assign out_ch.handshake_level = out_hs_reg;
    assign out_ch.rx_not_empty    = out_rxne_reg;
    assign out_ch.package_ready   = out_pkrdy_reg;
    assign out_ch.rx_overflow     = out_ovf_reg;
    assign out_ch.tx_dropped      = out_drop_reg;

    // Neither FIFO count may ever pass the FIFO depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        rx_count_reg <= DEPTH_CNT && tx_count_reg <= DEPTH_CNT)
        else $error("FIFO count beyond depth");

    // With the transmit chain idle nothing is queued and the request line is low.
    assert property (@(posedge clk) disable iff (!rst_n)
        !chain_busy_reg |-> (tx_count_reg == '0 && !request_line_reg))
        else $error("transmit chain idle with bytes pending");

    // A waiting result that is not the last of its beat belongs to a packet read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |->
            (state_reg == ST_PK_READ || state_reg == ST_PK_EMIT))
        else $error("non-final result outside a packet read");

    // A result without real data always carries the empty code.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_dvalid_reg) |-> out_data_reg == EMPTY_CODE)
        else $error("empty result with wrong data code");

    // A packet header is only tested with a whole packet in the receive FIFO.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PK_TEST |-> rx_count_reg >= PACKET_CNT)
        else $error("packet header tested on a short FIFO");

endmodule
